// ===== hw/rtl/fpalu_pkg.sv =====
`default_nettype none
package fpalu_pkg;

    localparam int FRAC_BITS  = 8;
    localparam int DATA_W     = 32;
    localparam int NUM_W      = DATA_W + FRAC_BITS;
    localparam int DIV_STEP   = 2;
    localparam int DIV_STAGES = (NUM_W + DIV_STEP - 1) / DIV_STEP;
    localparam int QW         = DIV_STAGES * DIV_STEP;
    localparam int WIDE_W     = 64;

    typedef enum logic [3:0] {
        OP_ADD  = 4'd0,
        OP_SUB  = 4'd1,
        OP_MUL  = 4'd2,
        OP_DIV  = 4'd3,
        OP_GT   = 4'd4,
        OP_LT   = 4'd5,
        OP_GE   = 4'd6,
        OP_LE   = 4'd7,
        OP_EQ   = 4'd8,
        OP_NE   = 4'd9,
        OP_MIN  = 4'd10,
        OP_MAX  = 4'd11,
        OP_INC  = 4'd12,
        OP_DEC  = 4'd13,
        OP_FINT = 4'd14,
        OP_TINT = 4'd15
    } op_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_OVF  = 2'd1,
        ST_DIVZ = 2'd2
    } status_t;

    typedef struct packed {
        op_t                op;
        logic [DATA_W-1:0]  simple_res;
        status_t            simple_st;
        logic               neg;
        logic [DATA_W-1:0]  mag_a;
        logic [DATA_W-1:0]  mag_b;
        logic [WIDE_W-1:0]  prod;
        logic [QW-1:0]      qn;
        logic [DATA_W-1:0]  rem;
    } pipe_t;

endpackage
`default_nettype wire

// ===== hw/rtl/fixed_point_alu_q24_8.sv =====
// Signed Q24.8 fixed-point arithmetic unit.
// The input channel (in_valid, in_ready) carries an operation code and two
// 32-bit raw operands; the output channel (out_valid, out_ready) carries one
// result_value and one status for every accepted item, in order.
// The unit is a stall-all pipeline: an item can enter in every cycle and
// passes through a preparation stage, 20 divider stages that each retire
// two quotient bits, and then the output register. The 40 quotient bits
// of the restoring divider set the depth; every operation uses the same
// latency so results stay in order. The multiplier sits in the first
// divider stage and its product is rounded in the final stage.
// Throughput is one item per cycle while out_ready is high.
// When the receiver holds out_ready low with a result waiting, the whole
// pipeline freezes and in_ready drops; nothing is lost or repeated.
// Reset clears all valid bits; payload registers are not reset.
// Overflow saturates with status 1; division by zero gives 0 with status 2.
`default_nettype none
module fixed_point_alu_q24_8 (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [3:0]  operation,
    input  wire logic signed [31:0] operand_a,
    input  wire logic signed [31:0] operand_b,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic signed [31:0] result_value,
    output logic [1:0]       status
);

    localparam int NS = fpalu_pkg::DIV_STAGES + 1;
    localparam int DW = fpalu_pkg::DATA_W;
    localparam int WW = fpalu_pkg::WIDE_W;
    localparam int QW = fpalu_pkg::QW;

    logic                 en;
    logic [NS-1:0]        v_reg;
    fpalu_pkg::pipe_t     p_reg  [NS];
    fpalu_pkg::pipe_t     p_next [NS];
    logic                 out_valid_reg;
    logic [DW-1:0]        res_reg;
    logic [DW-1:0]        res_next;
    fpalu_pkg::status_t   st_reg;
    fpalu_pkg::status_t   st_next;

    function automatic logic [DW+1:0] sat_mag(input logic neg, input logic [WW-1:0] m);
        logic [DW-1:0] lo;
        lo = m[DW-1:0];
        if (!neg) begin
            if (m > WW'({1'b0, {(DW-1){1'b1}}}))
                sat_mag = {fpalu_pkg::ST_OVF, 1'b0, {(DW-1){1'b1}}};
            else
                sat_mag = {fpalu_pkg::ST_OK, lo};
        end else begin
            if (m > WW'({1'b1, {(DW-1){1'b0}}}))
                sat_mag = {fpalu_pkg::ST_OVF, 1'b1, {(DW-1){1'b0}}};
            else
                sat_mag = {fpalu_pkg::ST_OK, (~lo) + DW'(1)};
        end
    endfunction

    assign en       = !out_valid_reg || out_ready;
    assign in_ready = en;

    always_comb
    begin
        logic [DW:0]    sum;
        logic [DW:0]    dif;
        logic [WW-1:0]  fext;
        logic [DW-1:0]  ua;
        logic [DW-1:0]  ub;
        logic           lt;
        logic           eq;
        p_next[0]            = '0;
        p_next[0].op         = fpalu_pkg::op_t'(operation);
        ua                   = operand_a;
        ub                   = operand_b;
        p_next[0].neg        = ua[DW-1] ^ ub[DW-1];
        p_next[0].mag_a      = ua[DW-1] ? (~ua) + DW'(1) : ua;
        p_next[0].mag_b      = ub[DW-1] ? (~ub) + DW'(1) : ub;
        p_next[0].qn         = QW'(p_next[0].mag_a) << fpalu_pkg::FRAC_BITS;
        p_next[0].simple_st  = fpalu_pkg::ST_OK;
        lt   = operand_a < operand_b;
        eq   = operand_a == operand_b;
        sum  = {ua[DW-1], ua} + {ub[DW-1], ub};
        dif  = {ua[DW-1], ua} - {ub[DW-1], ub};
        fext = {{(WW-DW){ua[DW-1]}}, ua} << fpalu_pkg::FRAC_BITS;
        case (fpalu_pkg::op_t'(operation))
            fpalu_pkg::OP_ADD, fpalu_pkg::OP_INC:
            begin
                if (fpalu_pkg::op_t'(operation) == fpalu_pkg::OP_INC)
                    sum = {ua[DW-1], ua} + (DW+1)'(1);
                if (sum[DW] != sum[DW-1])
                begin
                    p_next[0].simple_res = sum[DW] ? {1'b1, {(DW-1){1'b0}}}
                                                   : {1'b0, {(DW-1){1'b1}}};
                    p_next[0].simple_st  = fpalu_pkg::ST_OVF;
                end else
                    p_next[0].simple_res = sum[DW-1:0];
            end
            fpalu_pkg::OP_SUB, fpalu_pkg::OP_DEC:
            begin
                if (fpalu_pkg::op_t'(operation) == fpalu_pkg::OP_DEC)
                    dif = {ua[DW-1], ua} - (DW+1)'(1);
                if (dif[DW] != dif[DW-1])
                begin
                    p_next[0].simple_res = dif[DW] ? {1'b1, {(DW-1){1'b0}}}
                                                   : {1'b0, {(DW-1){1'b1}}};
                    p_next[0].simple_st  = fpalu_pkg::ST_OVF;
                end else
                    p_next[0].simple_res = dif[DW-1:0];
            end
            fpalu_pkg::OP_GT:  p_next[0].simple_res = DW'(!lt && !eq);
            fpalu_pkg::OP_LT:  p_next[0].simple_res = DW'(lt);
            fpalu_pkg::OP_GE:  p_next[0].simple_res = DW'(!lt);
            fpalu_pkg::OP_LE:  p_next[0].simple_res = DW'(lt || eq);
            fpalu_pkg::OP_EQ:  p_next[0].simple_res = DW'(eq);
            fpalu_pkg::OP_NE:  p_next[0].simple_res = DW'(!eq);
            fpalu_pkg::OP_MIN: p_next[0].simple_res = lt ? ua : ub;
            fpalu_pkg::OP_MAX: p_next[0].simple_res = (!lt && !eq) ? ua : ub;
            fpalu_pkg::OP_FINT:
            begin
                if ((&fext[WW-1:DW-1]) || !(|fext[WW-1:DW-1]))
                    p_next[0].simple_res = fext[DW-1:0];
                else
                begin
                    p_next[0].simple_res = ua[DW-1] ? {1'b1, {(DW-1){1'b0}}}
                                                    : {1'b0, {(DW-1){1'b1}}};
                    p_next[0].simple_st  = fpalu_pkg::ST_OVF;
                end
            end
            fpalu_pkg::OP_TINT:
                p_next[0].simple_res = DW'(operand_a >>> fpalu_pkg::FRAC_BITS);
            default: p_next[0].simple_res = '0;
        endcase
    end

    for (genvar s = 1; s < NS; s++)
    begin : g_div
        always_comb
        begin
            logic [DW:0] r2;
            p_next[s] = p_reg[s-1];
            if (s == 1)
                p_next[s].prod = WW'(p_reg[s-1].mag_a) * WW'(p_reg[s-1].mag_b);
            for (int k = 0; k < fpalu_pkg::DIV_STEP; k++)
            begin
                r2 = {p_next[s].rem, p_next[s].qn[QW-1]};
                if (r2 >= {1'b0, p_next[s].mag_b})
                begin
                    p_next[s].rem = DW'(r2 - {1'b0, p_next[s].mag_b});
                    p_next[s].qn  = {p_next[s].qn[QW-2:0], 1'b1};
                end else
                begin
                    p_next[s].rem = r2[DW-1:0];
                    p_next[s].qn  = {p_next[s].qn[QW-2:0], 1'b0};
                end
            end
        end
    end

    always_comb
    begin
        fpalu_pkg::pipe_t  f;
        logic [WW-1:0]     qm;
        logic [WW-1:0]     qd;
        logic [DW+1:0]     sr;
        f  = p_reg[NS-1];
        sr = '0;
        qm = (f.prod + (WW'(1) << (fpalu_pkg::FRAC_BITS - 1))) >> fpalu_pkg::FRAC_BITS;
        qd = WW'(f.qn) + WW'({f.rem, 1'b0} >= {1'b0, f.mag_b});
        res_next = f.simple_res;
        st_next  = f.simple_st;
        case (f.op)
            fpalu_pkg::OP_MUL:
            begin
                sr       = sat_mag(f.neg, qm);
                res_next = sr[DW-1:0];
                st_next  = fpalu_pkg::status_t'(sr[DW+1:DW]);
            end
            fpalu_pkg::OP_DIV:
            begin
                if (f.mag_b == '0)
                begin
                    res_next = '0;
                    st_next  = fpalu_pkg::ST_DIVZ;
                end else
                begin
                    sr       = sat_mag(f.neg, qd);
                    res_next = sr[DW-1:0];
                    st_next  = fpalu_pkg::status_t'(sr[DW+1:DW]);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg         <= '0;
            out_valid_reg <= 1'b0;
        end else if (en)
        begin
            v_reg         <= {v_reg[NS-2:0], in_valid};
            out_valid_reg <= v_reg[NS-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int s = 0; s < NS; s++)
                p_reg[s] <= p_next[s];
            res_reg <= res_next;
            st_reg  <= st_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign result_value = res_reg;
    assign status       = st_reg;

    a_no_bad_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status != 2'd3)
        else $error("status code out of range");

    a_divz_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == fpalu_pkg::ST_DIVZ |-> result_value == '0)
        else $error("division by zero gave a nonzero result");

    a_enter: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> v_reg[0])
        else $error("accepted item did not enter the pipeline");

endmodule
`default_nettype wire

// ===== bench/fixed_point_alu_q24_8_tb.sv =====
`default_nettype none
module fixed_point_alu_q24_8_tb;

    localparam int PERIOD = 20;
    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_ITEMS = 1050;
    localparam int DRAIN_CYCLES = 40;
    localparam logic signed [31:0] MAXV = 32'sh7fffffff;
    localparam logic signed [31:0] MINV = 32'sh80000000;

    typedef struct {
        fpalu_pkg::op_t op;
        logic signed [31:0] a;
        logic signed [31:0] b;
        logic check_fixed;
        logic signed [31:0] want_value;
        fpalu_pkg::status_t want_status;
    } vector_t;

    typedef struct {
        logic signed [31:0] value;
        fpalu_pkg::status_t st;
    } answer_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [3:0] operation = '0;
    logic signed [31:0] operand_a = '0;
    logic signed [31:0] operand_b = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic signed [31:0] result_value;
    logic [1:0] status;

    answer_t pending_answers[$];
    vector_t directed[$];
    int mismatches = 0;
    int results_seen = 0;
    int cycle_count = 0;
    int op_hits[16];
    int sat_hits = 0;
    int divz_hits = 0;
    bit stimulus_done = 1'b0;

    fixed_point_alu_q24_8 dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .operation(operation),
        .operand_a(operand_a),
        .operand_b(operand_b),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .result_value(result_value),
        .status(status)
    );

    always #(PERIOD / 2) clk = ~clk;

    function automatic answer_t saturate(input logic signed [65:0] v);
        answer_t r;
        r.st = fpalu_pkg::ST_OK;
        if (v > 66'sd2147483647) begin
            r.value = MAXV;
            r.st = fpalu_pkg::ST_OVF;
        end
        else if (v < -66'sd2147483648) begin
            r.value = MINV;
            r.st = fpalu_pkg::ST_OVF;
        end
        else begin
            r.value = v[31:0];
        end
        return r;
    endfunction

    function automatic answer_t alu_answer(input fpalu_pkg::op_t op,
                                           input logic signed [31:0] a,
                                           input logic signed [31:0] b);
        answer_t r;
        logic signed [65:0] wa;
        logic signed [65:0] wb;
        logic [65:0] ma;
        logic [65:0] mb;
        logic [65:0] q;
        logic [65:0] rem;
        logic neg;
        wa = a;
        wb = b;
        ma = (wa < 0) ? -wa : wa;
        mb = (wb < 0) ? -wb : wb;
        neg = (a < 0) != (b < 0);
        r.value = '0;
        r.st = fpalu_pkg::ST_OK;
        case (op)
            fpalu_pkg::OP_ADD: r = saturate(wa + wb);
            fpalu_pkg::OP_SUB: r = saturate(wa - wb);
            fpalu_pkg::OP_MUL:
            begin
                q = (ma * mb + (66'd1 << (fpalu_pkg::FRAC_BITS - 1))) >> fpalu_pkg::FRAC_BITS;
                r = saturate(neg ? -$signed(q) : $signed(q));
            end
            fpalu_pkg::OP_DIV:
            begin
                if (b == 0) begin
                    r.st = fpalu_pkg::ST_DIVZ;
                end
                else begin
                    q = (ma << fpalu_pkg::FRAC_BITS) / mb;
                    rem = (ma << fpalu_pkg::FRAC_BITS) % mb;
                    if (rem >= mb - rem) q = q + 1;
                    r = saturate(neg ? -$signed(q) : $signed(q));
                end
            end
            fpalu_pkg::OP_GT: r.value = a > b;
            fpalu_pkg::OP_LT: r.value = a < b;
            fpalu_pkg::OP_GE: r.value = a >= b;
            fpalu_pkg::OP_LE: r.value = a <= b;
            fpalu_pkg::OP_EQ: r.value = a == b;
            fpalu_pkg::OP_NE: r.value = a != b;
            fpalu_pkg::OP_MIN: r.value = (a < b) ? a : b;
            fpalu_pkg::OP_MAX: r.value = (a > b) ? a : b;
            fpalu_pkg::OP_INC: r = saturate(wa + 1);
            fpalu_pkg::OP_DEC: r = saturate(wa - 1);
            fpalu_pkg::OP_FINT: r = saturate(wa * (66'sd1 <<< fpalu_pkg::FRAC_BITS));
            default: r.value = a >>> fpalu_pkg::FRAC_BITS;
        endcase
        return r;
    endfunction

    function automatic logic signed [31:0] pick_operand();
        case ($urandom_range(0, 9))
            0: return MAXV;
            1: return MINV;
            2: return 32'($signed($urandom_range(0, 8)) - 4);
            3, 4: return 32'($signed($urandom_range(0, 65535)) - 32768);
            5, 6: return 32'($signed($urandom_range(0, 33554431)) - 16777216);
            default: return $signed($urandom());
        endcase
    endfunction

    function automatic vector_t row(input fpalu_pkg::op_t op, input logic signed [31:0] a,
                                    input logic signed [31:0] b, input logic fixed,
                                    input logic signed [31:0] v,
                                    input fpalu_pkg::status_t s);
        vector_t t;
        t.op = op;
        t.a = a;
        t.b = b;
        t.check_fixed = fixed;
        t.want_value = v;
        t.want_status = s;
        return t;
    endfunction

    task automatic send_item(input fpalu_pkg::op_t op, input logic signed [31:0] a,
                             input logic signed [31:0] b);
        answer_t ans;
        if ($urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(0, 9) == 0 ? $urandom_range(5, 30) : $urandom_range(1, 3))
                @(posedge clk);
        end
        ans = alu_answer(op, a, b);
        in_valid <= 1'b1;
        operation <= op;
        operand_a <= a;
        operand_b <= b;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        pending_answers.push_back(ans);
        op_hits[op]++;
        if (ans.st == fpalu_pkg::ST_OVF) sat_hits++;
        if (ans.st == fpalu_pkg::ST_DIVZ) divz_hits++;
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_answers.size() != 0) @(posedge clk);
    endtask

    always @(posedge clk) begin
        if (!rst_n || !stimulus_done) begin
            out_ready <= (!rst_n) ? 1'b0 :
                ($urandom_range(0, 15) == 0 ? 1'b0 : ($urandom_range(0, 3) != 0));
        end
        else begin
            out_ready <= ($urandom_range(0, 3) != 0);
        end
    end

    always @(posedge clk) begin
        answer_t exp_ans;
        if (rst_n && out_valid && out_ready) begin
            results_seen++;
            if (pending_answers.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("Unexpected result %0d status %0d",
                                               result_value, status);
            end
            else begin
                exp_ans = pending_answers.pop_front();
                if (result_value !== exp_ans.value || status !== exp_ans.st) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Mismatch: expected %0d/%0d, got %0d/%0d",
                                 exp_ans.value, exp_ans.st, result_value, status);
                end
            end
        end
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        answer_t got;
        fpalu_pkg::op_t op;
        foreach (op_hits[i]) op_hits[i] = 0;
        directed.push_back(row(fpalu_pkg::OP_ADD, MAXV, 32'sd1, 1'b1,
                               MAXV, fpalu_pkg::ST_OVF));
        directed.push_back(row(fpalu_pkg::OP_ADD, MINV, -32'sd1, 1'b1,
                               MINV, fpalu_pkg::ST_OVF));
        directed.push_back(row(fpalu_pkg::OP_SUB, MINV, 32'sd1, 1'b1,
                               MINV, fpalu_pkg::ST_OVF));
        directed.push_back(row(fpalu_pkg::OP_SUB, 32'sd0, MINV, 1'b1,
                               MAXV, fpalu_pkg::ST_OVF));
        directed.push_back(row(fpalu_pkg::OP_MUL, 32'sd384, 32'sd384, 1'b1,
                               32'sd576, fpalu_pkg::ST_OK));
        directed.push_back(row(fpalu_pkg::OP_MUL, 32'sd1, 32'sd128, 1'b1,
                               32'sd1, fpalu_pkg::ST_OK));
        directed.push_back(row(fpalu_pkg::OP_MUL, -32'sd1, 32'sd128, 1'b1,
                               -32'sd1, fpalu_pkg::ST_OK));
        directed.push_back(row(fpalu_pkg::OP_MUL, MINV, MINV, 1'b1,
                               MAXV, fpalu_pkg::ST_OVF));
        directed.push_back(row(fpalu_pkg::OP_MUL, MAXV, MINV, 1'b1,
                               MINV, fpalu_pkg::ST_OVF));
        directed.push_back(row(fpalu_pkg::OP_DIV, 32'sd256, 32'sd0, 1'b1,
                               32'sd0, fpalu_pkg::ST_DIVZ));
        directed.push_back(row(fpalu_pkg::OP_DIV, MINV, 32'sd0, 1'b1,
                               32'sd0, fpalu_pkg::ST_DIVZ));
        directed.push_back(row(fpalu_pkg::OP_DIV, MINV, 32'sd1, 1'b1,
                               MINV, fpalu_pkg::ST_OVF));
        directed.push_back(row(fpalu_pkg::OP_DIV, 32'sd1, 32'sd512, 1'b0,
                               32'sd0, fpalu_pkg::ST_OK));
        directed.push_back(row(fpalu_pkg::OP_DIV, -32'sd768, MINV, 1'b0,
                               32'sd0, fpalu_pkg::ST_OK));
        directed.push_back(row(fpalu_pkg::OP_GT, MAXV, MINV, 1'b1,
                               32'sd1, fpalu_pkg::ST_OK));
        directed.push_back(row(fpalu_pkg::OP_LT, MAXV, MINV, 1'b1,
                               32'sd0, fpalu_pkg::ST_OK));
        directed.push_back(row(fpalu_pkg::OP_GE, MINV, MINV, 1'b1,
                               32'sd1, fpalu_pkg::ST_OK));
        directed.push_back(row(fpalu_pkg::OP_LE, MAXV, MAXV, 1'b1,
                               32'sd1, fpalu_pkg::ST_OK));
        directed.push_back(row(fpalu_pkg::OP_EQ, -32'sd1, -32'sd1, 1'b1,
                               32'sd1, fpalu_pkg::ST_OK));
        directed.push_back(row(fpalu_pkg::OP_NE, MINV, MAXV, 1'b1,
                               32'sd1, fpalu_pkg::ST_OK));
        directed.push_back(row(fpalu_pkg::OP_MIN, MAXV, MINV, 1'b1,
                               MINV, fpalu_pkg::ST_OK));
        directed.push_back(row(fpalu_pkg::OP_MAX, MAXV, MINV, 1'b1,
                               MAXV, fpalu_pkg::ST_OK));
        directed.push_back(row(fpalu_pkg::OP_INC, MAXV, 32'sd5, 1'b1,
                               MAXV, fpalu_pkg::ST_OVF));
        directed.push_back(row(fpalu_pkg::OP_DEC, MINV, -32'sd5, 1'b1,
                               MINV, fpalu_pkg::ST_OVF));
        directed.push_back(row(fpalu_pkg::OP_FINT, 32'sh00800000, 32'sd0, 1'b1,
                               MAXV, fpalu_pkg::ST_OVF));
        directed.push_back(row(fpalu_pkg::OP_FINT, 32'shff800000, 32'sd0, 1'b1,
                               MINV, fpalu_pkg::ST_OK));
        directed.push_back(row(fpalu_pkg::OP_TINT, MINV, MAXV, 1'b1,
                               32'shff800000, fpalu_pkg::ST_OK));
        directed.push_back(row(fpalu_pkg::OP_TINT, -32'sd1, 32'sd0, 1'b1,
                               -32'sd1, fpalu_pkg::ST_OK));

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i]) begin
            if (directed[i].check_fixed) begin
                got = alu_answer(directed[i].op, directed[i].a, directed[i].b);
                if (got.value !== directed[i].want_value || got.st !== directed[i].want_status)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Table row %0d disagrees with predictor", i);
                end
            end
            send_item(directed[i].op, directed[i].a, directed[i].b);
        end

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            op = fpalu_pkg::op_t'($urandom_range(0, 15));
            send_item(op, pick_operand(), ($urandom_range(0, 19) == 0) ? 32'sd0 : pick_operand());
            if (n == RANDOM_ITEMS / 2) wait_drained();
        end

        stimulus_done = 1'b1;
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Checked %0d results over 16 operations, %0d saturations, %0d divides by zero.",
                 results_seen, sat_hits, divz_hits);
        if (mismatches == 0 && pending_answers.size() == 0) begin
            $display("All tests passed");
        end
        else begin
            $display("Mismatches: %0d, still pending: %0d", mismatches, pending_answers.size());
            $display("Some tests failed");
        end
        $finish;
    end
endmodule
`default_nettype wire
